// File: rtl/bitmap_first_free_allocator_macros.svh
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef BITMAP_FIRST_FREE_ALLOCATOR_MACROS_SVH
`define BITMAP_FIRST_FREE_ALLOCATOR_MACROS_SVH

// consequent checked in the same cycle
`define BFFA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define BFFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bffa_pkg.sv
package bffa_pkg;

  localparam int NUM_W         = 14;
  localparam int STAT_W        = 2;
  localparam int MAP_BITS_DEF  = 8192;
  localparam int WORD_BITS_DEF = 64;
  // widest bit index inside a word (word is at most 64 bits)
  localparam int IDX_MAX_W     = 6;
  // shift of the reciprocal used to split a bit number into word and bit
  localparam int DIV_SHIFT     = 21;

  localparam logic [NUM_W-1:0] SIZE_RESET = NUM_W'(8192);

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] ST_FREED = 2'd3;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic                 found;
    logic [IDX_MAX_W-1:0] idx;
  } find_t;

endpackage

// File: rtl/bffa_ifs.sv
interface bffa_in_if import bffa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [NUM_W-1:0] number;

  modport source (output valid, output mode, output number, input ready);
  modport sink (input valid, input mode, input number, output ready);
endinterface

interface bffa_out_if import bffa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [NUM_W-1:0]  result_number;
  logic [STAT_W-1:0] status;
  logic [NUM_W-1:0]  free_count;

  modport source (output valid, output result_number, output status, output free_count,
                  input ready);
  modport sink (input valid, input result_number, input status, input free_count,
                output ready);
endinterface

interface bffa_cfg_if import bffa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/bffa_mem.sv
module bffa_mem import bffa_pkg::*; #(
  parameter int DEPTH = MAP_BITS_DEF / WORD_BITS_DEF,
  parameter int WIDTH = WORD_BITS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// File: rtl/bffa_find.sv
module bffa_find import bffa_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int LIM_W     = $clog2(WORD_BITS + 1)
) (
  input  logic [WORD_BITS-1:0] word,
  input  logic [LIM_W-1:0]     lim,
  output find_t                fnd
);

  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] avail;
  logic [WORD_BITS-1:0] low;

  // only bits below the map size count
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      mask[b] = (LIM_W'(b) < lim);
    end
  end

  assign avail = ~word & mask;
  // isolate the lowest clear bit
  assign low   = avail & (~avail + WORD_BITS'(1));

  always_comb begin
    fnd.found = |avail;
    for (int j = 0; j < IDX_MAX_W; j++) begin
      fnd.idx[j] = 1'b0;
      for (int b = 0; b < WORD_BITS; b++) begin
        if (((b >> j) & 1) == 1) begin
          fnd.idx[j] = fnd.idx[j] | low[b];
        end
      end
    end
  end

endmodule

// File: rtl/bffa_divw.sv
module bffa_divw import bffa_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int AW        = 7,
  parameter int BW        = $clog2(WORD_BITS)
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] nm1,
  output logic [AW-1:0]    q_r,
  output logic [BW-1:0]    rem
);

  localparam int RECIP  = (2**DIV_SHIFT + WORD_BITS - 1) / WORD_BITS;
  localparam int PROD_W = DIV_SHIFT + NUM_W;

  logic [PROD_W-1:0] prod;
  logic [NUM_W-1:0]  n_r;
  logic [NUM_W-1:0]  qw;
  logic [NUM_W-1:0]  diff;

  // quotient by reciprocal, exact for 14-bit numbers
  assign prod = {{(PROD_W-NUM_W){1'b0}}, nm1} * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      n_r <= nm1;
      q_r <= prod[DIV_SHIFT +: AW];
    end
  end

  assign qw   = NUM_W'({{(NUM_W-AW){1'b0}}, q_r} * NUM_W'(WORD_BITS));
  assign diff = n_r - qw;
  assign rem  = diff[BW-1:0];

endmodule

// File: rtl/bitmap_first_free_allocator.sv
// channel   dir  payload                               handshake
// cfg_ch    in   data (map size, 14b)                  valid/ready, always ready
// in_ch     in   mode (1b), number (14b)               valid/ready
// out_ch    out  result_number, status, free_count     valid/ready, output register
//
// allocate: the accept cycle, one bitmap word read per cycle, a check of the
//   last word read, a further scan step that reports full when no word had a
//   free bit, then the load of the result; the words are read through the single read
//   port of the bitmap memory
// free: split number, read word, modify/write, result; out of range: straight to the result
// after reset a clearing pass writes every bitmap word (128 words by default),
//   with in_ch.ready low; cfg writes are taken throughout
// a stalled out_ch holds the finished result while the next request is accepted
// and worked on; that one waits for the output register to drain
module bitmap_first_free_allocator import bffa_pkg::*; #(
  parameter int MAP_BITS  = MAP_BITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  bffa_cfg_if.sink   cfg_ch,
  bffa_in_if.sink    in_ch,
  bffa_out_if.source out_ch
);

`include "bitmap_first_free_allocator_macros.svh"

  localparam int WORD_COUNT = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BW         = $clog2(WORD_BITS);
  localparam int LIM_W      = $clog2(WORD_BITS + 1);
  localparam int BASE_W     = $clog2(2**NUM_W + WORD_BITS);
  localparam int MAX_SIZE   = (MAP_BITS < 2**NUM_W) ? MAP_BITS : 2**NUM_W - 1;

  localparam logic [2:0] SM_CLEAR = 3'd0;
  localparam logic [2:0] SM_IDLE  = 3'd1;
  localparam logic [2:0] SM_SCAN  = 3'd2;
  localparam logic [2:0] SM_FDIV  = 3'd3;
  localparam logic [2:0] SM_FCHK  = 3'd4;
  localparam logic [2:0] SM_DONE  = 3'd5;

  logic [2:0] state_r, state_nxt;

  // configuration and counters
  logic [NUM_W-1:0] map_size_r;
  logic [NUM_W-1:0] eff_size;
  logic [NUM_W-1:0] used_r, used_nxt;
  logic [AW-1:0]    clr_w_r, clr_w_nxt;

  // scan pipe: issue side and read-data side
  logic [AW-1:0]     iss_w_r, iss_w_nxt;
  logic [BASE_W-1:0] iss_base_r, iss_base_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     pend_w_r, pend_w_nxt;
  logic [BASE_W-1:0] pend_base_r, pend_base_nxt;
  logic              issue;
  logic              hit;
  logic [BASE_W-1:0] room;
  logic [LIM_W-1:0]  lim;
  find_t             fnd;

  // free path
  logic              div_en;
  logic [NUM_W-1:0]  nm1;
  logic [AW-1:0]     div_q;
  logic [BW-1:0]     div_rem;
  logic [AW-1:0]     fw_r, fw_nxt;
  logic [BW-1:0]     rem_r, rem_nxt;
  logic              in_range;

  // result staging and output register
  logic [NUM_W-1:0]  res_num_r, res_num_nxt;
  logic [STAT_W-1:0] res_stat_r, res_stat_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [NUM_W-1:0]  out_num_r, out_num_nxt;
  logic [STAT_W-1:0] out_stat_r, out_stat_nxt;
  logic [NUM_W-1:0]  out_free_r, out_free_nxt;
  logic [NUM_W-1:0]  free_left;
  logic              in_take;

  // bitmap memory ports
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  bffa_mem #(
    .DEPTH (WORD_COUNT),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

  bffa_find #(
    .WORD_BITS (WORD_BITS),
    .LIM_W     (LIM_W)
  ) u_find (
    .word (mem_rdata),
    .lim  (lim),
    .fnd  (fnd)
  );

  bffa_divw #(
    .WORD_BITS (WORD_BITS),
    .AW        (AW),
    .BW        (BW)
  ) u_divw (
    .clk (clk),
    .en  (div_en),
    .nm1 (nm1),
    .q_r (div_q),
    .rem (div_rem)
  );

  // size saturated to the map
  assign eff_size = (map_size_r > NUM_W'(MAX_SIZE)) ? NUM_W'(MAX_SIZE) : map_size_r;
  assign free_left = (used_r >= eff_size) ? '0 : eff_size - used_r;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == SM_IDLE);
  assign in_take      = in_ch.valid && in_ch.ready;

  assign in_range = (in_ch.number != '0) && (in_ch.number <= eff_size);
  assign nm1      = in_ch.number - NUM_W'(1);
  assign div_en   = in_take && (in_ch.mode == MODE_FREE);

  // valid bits left in the word now coming out of memory
  assign room  = BASE_W'(eff_size) - pend_base_r;
  assign lim   = (room >= BASE_W'(WORD_BITS)) ? LIM_W'(WORD_BITS) : room[LIM_W-1:0];
  assign hit   = (state_r == SM_SCAN) && pend_r && fnd.found;
  assign issue = (state_r == SM_SCAN) && !hit && (iss_base_r < BASE_W'(eff_size));

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    clr_w_nxt     = clr_w_r;
    iss_w_nxt     = iss_w_r;
    iss_base_nxt  = iss_base_r;
    pend_nxt      = 1'b0;
    pend_w_nxt    = iss_w_r;
    pend_base_nxt = iss_base_r;
    fw_nxt        = fw_r;
    rem_nxt       = rem_r;
    res_num_nxt   = res_num_r;
    res_stat_nxt  = res_stat_r;
    mem_we        = 1'b0;
    mem_waddr     = clr_w_r;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = iss_w_r;

    unique case (state_r)
      SM_CLEAR: begin
        // zero one word a cycle
        mem_we    = 1'b1;
        clr_w_nxt = clr_w_r + AW'(1);
        if (clr_w_r == AW'(WORD_COUNT - 1)) begin
          state_nxt = SM_IDLE;
        end
      end
      SM_IDLE: begin
        if (in_take) begin
          res_num_nxt = '0;
          if (in_ch.mode == MODE_ALLOC) begin
            iss_w_nxt    = '0;
            iss_base_nxt = '0;
            state_nxt    = SM_SCAN;
          end else if (!in_range) begin
            res_stat_nxt = ST_RANGE;
            state_nxt    = SM_DONE;
          end else begin
            state_nxt = SM_FDIV;
          end
        end
      end
      SM_SCAN: begin
        // read ahead one word while checking the previous one
        mem_re    = issue;
        mem_raddr = iss_w_r;
        pend_nxt  = issue;
        if (issue) begin
          iss_w_nxt    = iss_w_r + AW'(1);
          iss_base_nxt = iss_base_r + BASE_W'(WORD_BITS);
        end
        if (hit) begin
          mem_we       = 1'b1;
          mem_waddr    = pend_w_r;
          mem_wdata    = mem_rdata | (WORD_BITS'(1) << fnd.idx);
          used_nxt     = used_r + NUM_W'(1);
          res_num_nxt  = NUM_W'(pend_base_r + BASE_W'(fnd.idx) + BASE_W'(1));
          res_stat_nxt = ST_OK;
          state_nxt    = SM_DONE;
        end else if (!issue && !pend_r) begin
          res_stat_nxt = ST_FULL;
          state_nxt    = SM_DONE;
        end
      end
      SM_FDIV: begin
        mem_re    = 1'b1;
        mem_raddr = div_q;
        fw_nxt    = div_q;
        rem_nxt   = div_rem;
        state_nxt = SM_FCHK;
      end
      SM_FCHK: begin
        if (!mem_rdata[rem_r]) begin
          res_stat_nxt = ST_FREED;
        end else begin
          mem_we       = 1'b1;
          mem_waddr    = fw_r;
          mem_wdata    = mem_rdata & ~(WORD_BITS'(1) << rem_r);
          res_stat_nxt = ST_OK;
          if (used_r != '0) begin
            used_nxt = used_r - NUM_W'(1);
          end
        end
        state_nxt = SM_DONE;
      end
      SM_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = SM_IDLE;
        end
      end
      default: begin
        state_nxt = SM_IDLE;
      end
    endcase
  end

  // output register, loaded when the staged result can move
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_num_nxt   = out_num_r;
    out_stat_nxt  = out_stat_r;
    out_free_nxt  = out_free_r;
    if ((state_r == SM_DONE) && (!out_valid_r || out_ch.ready)) begin
      out_valid_nxt = 1'b1;
      out_num_nxt   = res_num_r;
      out_stat_nxt  = res_stat_r;
      out_free_nxt  = free_left;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SM_CLEAR;
      map_size_r  <= SIZE_RESET;
      used_r      <= '0;
      clr_w_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      clr_w_r     <= clr_w_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        map_size_r <= cfg_ch.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    iss_w_r     <= iss_w_nxt;
    iss_base_r  <= iss_base_nxt;
    pend_w_r    <= pend_w_nxt;
    pend_base_r <= pend_base_nxt;
    fw_r        <= fw_nxt;
    rem_r       <= rem_nxt;
    res_num_r   <= res_num_nxt;
    res_stat_r  <= res_stat_nxt;
    out_num_r   <= out_num_nxt;
    out_stat_r  <= out_stat_nxt;
    out_free_r  <= out_free_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_number = out_num_r;
  assign out_ch.status        = out_stat_r;
  assign out_ch.free_count    = out_free_r;

  // a full map leaves nothing free and hands out no number
  `BFFA_ASSERT_SAME(a_full_empty, out_ch.valid && (out_ch.status == ST_FULL), (out_ch.result_number == '0) && (out_ch.free_count == '0), "full result with number or free count")

  // the read-ahead never hits the word being written back
  `BFFA_ASSERT_SAME(a_no_rw_clash, mem_we && mem_re, mem_waddr != mem_raddr, "bitmap read and write to same word")

  // the used count moves by at most one per cycle
  `BFFA_ASSERT_NEXT(a_used_step, 1'b1, (used_r == $past(used_r)) || (used_r == $past(used_r) + NUM_W'(1)) || (used_r == $past(used_r) - NUM_W'(1)), "used count jumped")

endmodule
